[design/greedy_assignment_builder_core_assert.svh]
// Assertion macros for the greedy assignment builder.
// Used by the top level; expects clk and rst in scope.
`ifndef GREEDY_ASSIGNMENT_BUILDER_CORE_ASSERT_SVH
`define GREEDY_ASSIGNMENT_BUILDER_CORE_ASSERT_SVH

`define GAB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define GAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gab_pkg.sv]
// Shared constants, command codes, state type and control structs
// for the greedy assignment builder. No dependencies.
`timescale 1ns / 1ps

package gab_pkg;

  localparam int MAX_SIZE_DEFAULT = 32;
  localparam int CMD_W = 2;
  localparam int ROW_W = 5;
  localparam int ENTRY_W = 15;
  localparam int SIZE_W = 6;
  localparam int GENE_W = 6;
  localparam int PROD_W = 2 * ENTRY_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [CMD_W-1:0] CMD_LOAD_DIST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_FLOW = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_COMMIT = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } gab_state_t;

  typedef struct packed {
    logic load_dist;
    logic load_flow;
    logic start_run;
    logic issue;
    logic commit;
  } gab_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic run_last;
    logic pipe_busy;
  } gab_status_t;

endpackage

[design/gab_ctrl.sv]
// Controller state machine for the greedy assignment builder.
// Depends on gab_pkg; drives commands to gab_datapath.
`timescale 1ns / 1ps

module gab_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gab_pkg::CMD_W-1:0]  command,
  input  gab_pkg::gab_status_t       status,
  output gab_pkg::gab_cmd_t          cmd
);

  gab_pkg::gab_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gab_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      gab_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (command)
            gab_pkg::CMD_LOAD_DIST: cmd.load_dist = 1'b1;
            gab_pkg::CMD_LOAD_FLOW: cmd.load_flow = 1'b1;
            gab_pkg::CMD_START: begin
              cmd.start_run = 1'b1;
              state_next = gab_pkg::ST_COMMIT;
            end
            default: ;
          endcase
        end
      end
      gab_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = status.run_last ? gab_pkg::ST_IDLE : gab_pkg::ST_SCAN;
        end
      end
      gab_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_end) begin
          state_next = gab_pkg::ST_DRAIN;
        end
      end
      gab_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = gab_pkg::ST_COMMIT;
        end
      end
      default: state_next = gab_pkg::ST_IDLE;
    endcase
  end

endmodule

[design/gab_datapath.sv]
// Datapath: matrix stores, free mask, candidate scan pipeline,
// best-pick tracking and output register. Depends on gab_pkg.
`timescale 1ns / 1ps

module gab_datapath #(
  parameter int MAX_SIZE = gab_pkg::MAX_SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gab_pkg::gab_cmd_t            cmd,
  output gab_pkg::gab_status_t         status,
  input  logic                         cfg_wr_en,
  input  logic [gab_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  logic [gab_pkg::ROW_W-1:0]    row_index,
  input  logic [gab_pkg::ROW_W-1:0]    col_index,
  input  logic [gab_pkg::ENTRY_W-1:0]  entry_value,
  input  logic [gab_pkg::SIZE_W-1:0]   start_facility,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [gab_pkg::GENE_W-1:0]   gene,
  output logic                         last_gene
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W = $clog2(MAX_SIZE + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = 1 << ADDR_W;

  logic [gab_pkg::ENTRY_W-1:0] dist_mem [DEPTH];
  logic [gab_pkg::ENTRY_W-1:0] flow_mem [DEPTH];

  logic [gab_pkg::SIZE_W-1:0]  size_in_use;
  logic [CNT_W-1:0]            n_size;
  logic [CNT_W-1:0]            start_cl;
  logic                        load_ok;
  logic [ADDR_W-1:0]           wr_addr;

  logic [MAX_SIZE-1:0]         free_mask;
  logic [IDX_W-1:0]            prev_pick;
  logic [CNT_W-1:0]            pos;
  logic [IDX_W-1:0]            cand;

  logic [gab_pkg::ENTRY_W-1:0] dist_q;
  logic [gab_pkg::ENTRY_W-1:0] flow_q;
  logic                        v1;
  logic                        v2;
  logic                        f1;
  logic                        f2;
  logic [IDX_W-1:0]            c1;
  logic [IDX_W-1:0]            c2;
  logic [gab_pkg::PROD_W-1:0]  prod;

  logic                        found;
  logic [IDX_W-1:0]            best_idx;
  logic [gab_pkg::PROD_W-1:0]  best_cost;

  always_comb begin
    if (size_in_use == '0) begin
      n_size = CNT_W'(1);
    end else if (32'(size_in_use) > MAX_SIZE) begin
      n_size = CNT_W'(MAX_SIZE);
    end else begin
      n_size = CNT_W'(size_in_use);
    end
    if (start_facility == '0) begin
      start_cl = CNT_W'(1);
    end else if (32'(start_facility) > 32'(n_size)) begin
      start_cl = n_size;
    end else begin
      start_cl = CNT_W'(start_facility);
    end
  end

  assign load_ok = (32'(row_index) < MAX_SIZE) && (32'(col_index) < MAX_SIZE);
  assign wr_addr = {IDX_W'(row_index), IDX_W'(col_index)};

  assign status.out_free = !out_valid || out_ready;
  assign status.scan_end = (32'(cand) + 1) == 32'(n_size);
  assign status.run_last = (32'(pos) + 1) == 32'(n_size);
  assign status.pipe_busy = v1 || v2;

  always_ff @(posedge clk) begin
    if (cmd.load_dist && load_ok) begin
      dist_mem[wr_addr] <= entry_value;
    end
    dist_q <= dist_mem[{pos[IDX_W-1:0], cand}];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flow && load_ok) begin
      flow_mem[wr_addr] <= entry_value;
    end
    flow_q <= flow_mem[{prev_pick, cand}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= gab_pkg::SIZE_RESET;
      v1 <= 1'b0;
      v2 <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
      free_mask <= '1;
      prev_pick <= '0;
    end else begin
      if (cfg_wr_en) begin
        size_in_use <= cfg_wr_data;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.start_run || cmd.commit) begin
        found <= 1'b0;
      end else if (v2 && f2 && (!found || prod < best_cost)) begin
        found <= 1'b1;
      end
      if (cmd.start_run) begin
        free_mask <= '1;
      end else if (cmd.commit) begin
        free_mask[best_idx] <= 1'b0;
        prev_pick <= best_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    c1 <= cand;
    f1 <= free_mask[cand];
    c2 <= c1;
    f2 <= f1;
    prod <= gab_pkg::PROD_W'(flow_q) * gab_pkg::PROD_W'(dist_q);
    if (cmd.start_run) begin
      best_idx <= IDX_W'(start_cl - CNT_W'(1));
      pos <= '0;
      cand <= '0;
    end else if (cmd.commit) begin
      gene <= gab_pkg::GENE_W'(32'(best_idx) + 1);
      last_gene <= status.run_last;
      pos <= pos + CNT_W'(1);
      cand <= '0;
    end else begin
      if (cmd.issue) begin
        cand <= cand + IDX_W'(1);
      end
      if (v2 && f2 && (!found || prod < best_cost)) begin
        best_idx <= c2;
        best_cost <= prod;
      end
    end
  end

endmodule

[design/greedy_assignment_builder_core.sv]
// Top level of the greedy assignment builder: controller plus datapath.
// Depends on gab_pkg, gab_ctrl, gab_datapath and the assertion header.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in       | in_valid/in_ready   | command row_index col_index entry_value
//            |                     | start_facility
//   out      | out_valid/out_ready | gene last_gene
//   cfg      | cfg_wr_en           | cfg_wr_data (size_in_use)
//
// Load requests leave the controller in IDLE. A start request holds the input
// through a run over n facilities: the request, a commit for the start facility,
// then per later position a scan of the n candidates (one read of each matrix store
// per cycle), a drain of the read and multiply stages, and a commit.
// Reset is synchronous and needs no clearing pass; the stores are undefined
// until written. A stalled output holds the scan at its commit step.
`timescale 1ns / 1ps

`include "greedy_assignment_builder_core_assert.svh"

module greedy_assignment_builder_core #(
  parameter int MAX_SIZE = gab_pkg::MAX_SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [gab_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gab_pkg::CMD_W-1:0]    command,
  input  logic [gab_pkg::ROW_W-1:0]    row_index,
  input  logic [gab_pkg::ROW_W-1:0]    col_index,
  input  logic [gab_pkg::ENTRY_W-1:0]  entry_value,
  input  logic [gab_pkg::SIZE_W-1:0]   start_facility,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gab_pkg::GENE_W-1:0]   gene,
  output logic                         last_gene
);

  gab_pkg::gab_cmd_t    cmd;
  gab_pkg::gab_status_t status;

  gab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  gab_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .row_index      (row_index),
    .col_index      (col_index),
    .entry_value    (entry_value),
    .start_facility (start_facility),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .gene           (gene),
    .last_gene      (last_gene)
  );

  `GAB_ASSERT_SAME(a_commit_slot_free, cmd.commit, status.out_free, "commit into busy output")
  `GAB_ASSERT_SAME(a_commit_drained, cmd.commit, !status.pipe_busy, "commit with scan in flight")
  `GAB_ASSERT_NEXT(a_last_to_idle, cmd.commit && status.run_last, in_ready, "no idle after last")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for greedy_assignment_builder_core: matrix loads and greedy
// runs under several problem sizes, with bursty requests and a stalling result side.
// Depends on gab_pkg and the RTL; results are checked against an in-bench greedy model.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_N = gab_pkg::MAX_SIZE_DEFAULT;
  localparam int unsigned LOAD_N = 8;
  localparam logic [gab_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [gab_pkg::GENE_W-1:0] facility;
    logic                       final_pos;
  } placement_t;

  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  class greedy_tracker;
    int unsigned dist_mem [MAX_N*MAX_N];
    int unsigned flow_mem [MAX_N*MAX_N];
    logic [gab_pkg::SIZE_W-1:0] size_reg;
    placement_t pending_genes[$];
    int unsigned failures;

    function new();
      size_reg = gab_pkg::SIZE_RESET;
      failures = 0;
    endfunction

    function void set_size(logic [gab_pkg::SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    function int unsigned active_size();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_N) return MAX_N;
      return 32'(size_reg);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch %0d: %s", failures, what);
    endfunction

    function void add_gene(int unsigned facility, bit final_pos);
      placement_t slot;
      slot.facility = gab_pkg::GENE_W'(facility);
      slot.final_pos = final_pos;
      pending_genes.insert(pending_genes.size(), slot);
    endfunction

    function void place_facilities(int unsigned start_raw);
      int unsigned n, prev, best, best_cost, cost;
      bit found;
      bit [MAX_N-1:0] taken;
      n = active_size();
      prev = (start_raw < 1) ? 1 : start_raw;
      if (prev > n) prev = n;
      add_gene(prev, (n == 1));
      prev = prev - 1;
      taken = '0;
      taken[prev] = 1'b1;
      for (int unsigned pos = 1; pos < n; pos++) begin
        found = 1'b0;
        best = 0;
        best_cost = 0;
        for (int unsigned c = 0; c < n; c++) begin
          if (taken[c]) continue;
          cost = flow_mem[prev*MAX_N + c] * dist_mem[pos*MAX_N + c];
          if (!found || cost < best_cost) begin
            best_cost = cost;
            best = c;
            found = 1'b1;
          end
        end
        taken[best] = 1'b1;
        prev = best;
        add_gene(best + 1, (pos + 1 == n));
      end
    endfunction

    function void note_request(logic [gab_pkg::CMD_W-1:0] cmd, int unsigned row,
                               int unsigned col, int unsigned value, int unsigned start);
      case (cmd)
        gab_pkg::CMD_LOAD_DIST: dist_mem[row*MAX_N + col] = value;
        gab_pkg::CMD_LOAD_FLOW: flow_mem[row*MAX_N + col] = value;
        gab_pkg::CMD_START: place_facilities(start);
        default: ;
      endcase
    endfunction

    function void check_gene(logic [gab_pkg::GENE_W-1:0] got_gene, logic got_last);
      placement_t want;
      if (pending_genes.size() == 0) begin
        report($sformatf("unexpected result gene %0d last %0b", got_gene, got_last));
        return;
      end
      want = pending_genes.pop_front();
      if (got_gene !== want.facility || got_last !== want.final_pos)
        report($sformatf("gene exp %0d got %0d, last exp %0b got %0b",
                         want.facility, got_gene, want.final_pos, got_last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [gab_pkg::SIZE_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [gab_pkg::CMD_W-1:0] command = '0;
  logic [gab_pkg::ROW_W-1:0] row_index = '0;
  logic [gab_pkg::ROW_W-1:0] col_index = '0;
  logic [gab_pkg::ENTRY_W-1:0] entry_value = '0;
  logic [gab_pkg::SIZE_W-1:0] start_facility = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gab_pkg::GENE_W-1:0] gene;
  logic last_gene;

  greedy_tracker tracker;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  greedy_assignment_builder_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .row_index(row_index),
    .col_index(col_index),
    .entry_value(entry_value),
    .start_facility(start_facility),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gene(gene),
    .last_gene(last_gene)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_left[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_gene(gene, last_gene);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [gab_pkg::CMD_W-1:0] cmd, input int unsigned row,
                              input int unsigned col, input int unsigned value,
                              input int unsigned start);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    row_index <= row[gab_pkg::ROW_W-1:0];
    col_index <= col[gab_pkg::ROW_W-1:0];
    entry_value <= value[gab_pkg::ENTRY_W-1:0];
    start_facility <= start[gab_pkg::SIZE_W-1:0];
    do begin
      @(posedge clk);
    end while (!in_ready);
    tracker.note_request(cmd, 32'(row[gab_pkg::ROW_W-1:0]), 32'(col[gab_pkg::ROW_W-1:0]),
                         32'(value[gab_pkg::ENTRY_W-1:0]), 32'(start[gab_pkg::SIZE_W-1:0]));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_genes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned value);
    settle();
    cfg_wr_data <= value[gab_pkg::SIZE_W-1:0];
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_size(value[gab_pkg::SIZE_W-1:0]);
  endtask

  function automatic int unsigned pick_entry();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 3);
    if (r == 4) return 0;
    if (r == 5) return 32767;
    return $urandom_range(0, 32767);
  endfunction

  task automatic random_phase(input int unsigned size_code, input int unsigned count);
    int unsigned n, r, row, col, starts, start;
    write_size(size_code);
    n = tracker.active_size();
    starts = 0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      row = $urandom_range(0, 31);
      col = $urandom_range(0, 31);
      if ($urandom_range(0, 9) < 7) begin
        row = row % n;
        col = col % n;
      end
      if (r < 15 && (n < 16 || starts < 2)) begin
        starts++;
        start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, n);
        send_request(gab_pkg::CMD_START, row, col, $urandom_range(0, 32767), start);
      end else if (r < 20) begin
        send_request(CMD_UNUSED, row, col, $urandom_range(0, 32767), $urandom_range(0, 63));
      end else begin
        send_request($urandom_range(0, 1) ? gab_pkg::CMD_LOAD_FLOW : gab_pkg::CMD_LOAD_DIST,
                     row, col, pick_entry(), $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    int unsigned phase_sizes[16] = '{3, 1, 2, 5, 8, 0, 4, 6, 7, 2, 7, 3, 8, 5, 4, 6};
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load every entry that a run of up to LOAD_N facilities reads
    for (int unsigned r = 0; r < LOAD_N; r++) begin
      for (int unsigned c = 0; c < LOAD_N; c++) begin
        send_request(gab_pkg::CMD_LOAD_DIST, r, c, pick_entry(), 0);
        send_request(gab_pkg::CMD_LOAD_FLOW, r, c, pick_entry(), 0);
      end
    end

    write_size(LOAD_N);
    send_request(gab_pkg::CMD_START, 31, 31, 32767, 32);
    send_request(CMD_UNUSED, 31, 31, 32767, 63);
    write_size(4);
    for (int unsigned c = 0; c < 4; c++) send_request(gab_pkg::CMD_LOAD_DIST, 1, c, 0, 0);
    send_request(gab_pkg::CMD_START, 0, 0, 0, 0);
    send_request(gab_pkg::CMD_LOAD_FLOW, 0, 3, 32767, 0);
    send_request(gab_pkg::CMD_LOAD_DIST, 2, 3, 32767, 0);
    send_request(gab_pkg::CMD_START, 0, 0, 0, 63);
    write_size(1);
    send_request(gab_pkg::CMD_START, 0, 0, 0, 5);
    write_size(0);
    send_request(gab_pkg::CMD_START, 0, 0, 0, 0);

    foreach (phase_sizes[p]) random_phase(phase_sizes[p], 20);

    settle();
    if (tracker.failures == 0 && tracker.pending_genes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/gab_pkg.sv
design/gab_ctrl.sv
design/gab_datapath.sv
design/greedy_assignment_builder_core.sv
dv/tb_top.sv
